// File: rtl/core/mdx_pkg.sv
package mdx_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RegW  = 5;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SW      = 6'h2b;
  localparam logic [5:0] OP_LL      = 6'h30;

  // Function codes of the special opcode
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // Instruction classes
  localparam logic [1:0] CLS_NOP = 2'd0;
  localparam logic [1:0] CLS_R   = 2'd1;
  localparam logic [1:0] CLS_I   = 2'd2;
  localparam logic [1:0] CLS_J   = 2'd3;

  localparam logic [RegW-1:0] LINK_REG = 5'd31;

  // One forwarding candidate from a later stage
  typedef struct packed {
    logic             enable;
    logic [RegW-1:0]  dest;
    logic [WordW-1:0] value;
  } fwd_src_t;

  // Everything the execute logic produces for one instruction
  typedef struct packed {
    logic [WordW-1:0] exec_value;
    logic [RegW-1:0]  dest_reg;
    logic             reg_write;
    logic             mem_read;
    logic             mem_write;
    logic [WordW-1:0] store_data;
    logic             redirect;
    logic [WordW-1:0] redirect_target;
    logic [1:0]       inst_class;
  } exec_result_t;

endpackage

// File: rtl/core/mdx_forward.sv
module mdx_forward (
  input  logic [4:0]        src_reg,
  input  logic [31:0]       file_value,
  input  mdx_pkg::fwd_src_t ex_src,
  input  mdx_pkg::fwd_src_t wb_src,
  output logic [31:0]       operand
);
  import mdx_pkg::*;

  // The ex_src candidate wins over wb_src; register zero is never bypassed.
  always_comb begin
    operand = file_value;
    if (src_reg != '0 && ex_src.enable && ex_src.dest == src_reg) begin
      operand = ex_src.value;
    end else if (src_reg != '0 && wb_src.enable && wb_src.dest == src_reg) begin
      operand = wb_src.value;
    end
  end

endmodule

// File: rtl/core/mdx_execute.sv
module mdx_execute (
  input  logic [31:0]           instr_word,
  input  logic [31:0]           pc_plus_four,
  input  logic [31:0]           op_a,
  input  logic [31:0]           op_b,
  output mdx_pkg::exec_result_t result
);
  import mdx_pkg::*;

  logic [5:0]  op;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  shamt;
  logic [5:0]  funct;
  logic [15:0] imm;
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] addr_sum;
  logic [1:0]  cls;

  // Field split and immediate extension
  assign op       = instr_word[31:26];
  assign rt       = instr_word[20:16];
  assign rd       = instr_word[15:11];
  assign shamt    = instr_word[10:6];
  assign funct    = instr_word[5:0];
  assign imm      = instr_word[15:0];
  assign simm     = {{16{imm[15]}}, imm};
  assign zimm     = {16'h0000, imm};
  assign addr_sum = op_a + simm;

  // Class follows the opcode; the all-zero word is a nop
  always_comb begin
    if (instr_word == '0) begin
      cls = CLS_NOP;
    end else if (op == OP_SPECIAL) begin
      cls = CLS_R;
    end else if (op == OP_J || op == OP_JAL) begin
      cls = CLS_J;
    end else begin
      cls = CLS_I;
    end
  end

  // Operation select and control decode
  always_comb begin
    result                 = '0;
    result.store_data      = op_b;
    result.inst_class      = cls;
    case (cls)
      CLS_R: begin
        result.reg_write = 1'b1;
        case (funct)
          FN_ADD, FN_ADDU: result.exec_value = op_a + op_b;
          FN_SUB, FN_SUBU: result.exec_value = op_a - op_b;
          FN_AND:  result.exec_value = op_a & op_b;
          FN_OR:   result.exec_value = op_a | op_b;
          FN_NOR:  result.exec_value = ~(op_a | op_b);
          FN_SLT:  result.exec_value = {31'd0, $signed(op_a) < $signed(op_b)};
          FN_SLTU: result.exec_value = {31'd0, op_a < op_b};
          FN_SLL:  result.exec_value = op_b << shamt;
          FN_SRL:  result.exec_value = op_b >> shamt;
          FN_JR: begin
            result.reg_write       = 1'b0;
            result.redirect        = 1'b1;
            result.redirect_target = op_a;
          end
          default: result.reg_write = 1'b0;
        endcase
        if (result.reg_write) begin
          result.dest_reg = rd;
        end
      end
      CLS_J: begin
        result.redirect        = 1'b1;
        result.redirect_target = {pc_plus_four[31:28], instr_word[25:0], 2'b00};
        if (op == OP_JAL) begin
          result.exec_value = pc_plus_four + 32'd4;
          result.reg_write  = 1'b1;
          result.dest_reg   = LINK_REG;
        end
      end
      CLS_I: begin
        result.reg_write = 1'b1;
        case (op)
          OP_ADDI, OP_ADDIU: result.exec_value = addr_sum;
          OP_ANDI:  result.exec_value = op_a & zimm;
          OP_ORI:   result.exec_value = op_a | zimm;
          OP_LUI:   result.exec_value = {imm, 16'h0000};
          OP_SLTI:  result.exec_value = {31'd0, $signed(op_a) < $signed(simm)};
          OP_SLTIU: result.exec_value = {31'd0, op_a < simm};
          OP_LW: begin
            result.exec_value = addr_sum;
            result.mem_read   = 1'b1;
          end
          OP_LBU, OP_LHU, OP_LL: begin
            result.exec_value = addr_sum;
            result.reg_write  = 1'b0;
          end
          OP_SW: begin
            result.exec_value = addr_sum;
            result.mem_write  = 1'b1;
            result.reg_write  = 1'b0;
          end
          OP_BEQ, OP_BNE: begin
            result.reg_write       = 1'b0;
            result.redirect_target = pc_plus_four + {simm[29:0], 2'b00};
            result.redirect        = (op == OP_BEQ) ? (op_a == op_b) : (op_a != op_b);
          end
          default: result.reg_write = 1'b0;
        endcase
        if (result.reg_write) begin
          result.dest_reg = rt;
        end
      end
      default: begin
        result.inst_class = CLS_NOP;
      end
    endcase
  end

endmodule

// File: rtl/core/mips_decode_execute_unit.sv
// An accepted request passes the input register and then the result register to the master side.
// Throughput: one instruction per cycle while results are taken; the two registers form
// a two-entry pipeline that advances when the result register is empty or is drained.
// Decode, forwarding and the ALU sit as one combinational step between the two.
// Reset (rst, synchronous, active high) empties both registers; payload is not cleared.
module mips_decode_execute_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // instr_word, pc_plus_four, rs_value, rt_value, ex_fwd_enable, ex_fwd_reg,
  // ex_fwd_value, wb_fwd_enable, wb_fwd_reg, wb_fwd_value, zero fill
  input  logic [207:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // exec_value, dest_reg, reg_write, mem_read, mem_write, store_data, redirect,
  // redirect_target, inst_class, zero fill
  output logic [111:0] m_tdata
);
  import mdx_pkg::*;

  logic         in_valid;
  logic [203:0] in_data;
  logic         out_valid;
  exec_result_t out_res;
  logic         out_free;
  logic         in_free;

  fwd_src_t     ex_src;
  fwd_src_t     wb_src;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  exec_result_t exec_res;

  // Pipeline advance: the result register can load when empty or being drained
  assign out_free = !out_valid || m_tready;
  assign in_free  = !in_valid || out_free;
  assign s_tready = in_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && s_tvalid) begin
      in_data <= s_tdata[203:0];
    end
  end

  // Forwarding candidates unpacked from the registered request
  assign ex_src = '{enable: in_data[128], dest: in_data[133:129], value: in_data[165:134]};
  assign wb_src = '{enable: in_data[166], dest: in_data[171:167], value: in_data[203:172]};

  mdx_forward u_fwd_rs (
    .src_reg    (in_data[25:21]),
    .file_value (in_data[95:64]),
    .ex_src     (ex_src),
    .wb_src     (wb_src),
    .operand    (op_a)
  );

  mdx_forward u_fwd_rt (
    .src_reg    (in_data[20:16]),
    .file_value (in_data[127:96]),
    .ex_src     (ex_src),
    .wb_src     (wb_src),
    .operand    (op_b)
  );

  mdx_execute u_execute (
    .instr_word   (in_data[31:0]),
    .pc_plus_four (in_data[63:32]),
    .op_a         (op_a),
    .op_b         (op_b),
    .result       (exec_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      out_res <= exec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0,
                     out_res.inst_class,
                     out_res.redirect_target,
                     out_res.redirect,
                     out_res.store_data,
                     out_res.mem_write,
                     out_res.mem_read,
                     out_res.reg_write,
                     out_res.dest_reg,
                     out_res.exec_value};

endmodule

// File: rtl/core/mdx_checker.sv
module mdx_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [207:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Destination is zero whenever no register is written.
  a_dest_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[37] |-> m_tdata[36:32] == 5'd0)
    else $error("destination set without register write");

  // A nop neither writes nor redirects, and never touches memory.
  a_nop_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[106:105] == 2'd0 |->
      !m_tdata[37] && !m_tdata[38] && !m_tdata[39] && !m_tdata[72])
    else $error("nop produced side effects");

  // An instruction accepted into an empty, drained pipeline passes the input and result registers before it appears.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid && m_tready |=> ##1 m_tvalid)
    else $error("result did not appear after two cycles");

endmodule

bind mips_decode_execute_unit mdx_checker u_mdx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
